// ----- sv/tkb_pkg.sv -----
// ----------------------------------------------------------------------------
// tkb_pkg
// Shared types and constants for the top-k box selector.
// ----------------------------------------------------------------------------
package tkb_pkg;

	localparam int MAX_KEEP_DEF = 64;
	localparam int KEEP_W       = 7;
	localparam int SCORE_W      = 16;
	localparam int COORD_W      = 32;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [COORD_W-1:0] coord_x0;
		logic [COORD_W-1:0] coord_y0;
		logic [COORD_W-1:0] coord_x1;
		logic [COORD_W-1:0] coord_y1;
		logic               set_end;
	} box_in_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_x0;
		logic [COORD_W-1:0] out_y0;
		logic [COORD_W-1:0] out_x1;
		logic [COORD_W-1:0] out_y1;
		logic               final_box;
	} box_out_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic drain;
		logic clr;
	} cell_ctl_t;

endpackage

// ----- sv/tkb_cell.sv -----
// ----------------------------------------------------------------------------
// tkb_cell
// One rank slot of the sorted chain: takes the new box, the box of the slot
// above, or the box of the slot below while the set drains.
// ----------------------------------------------------------------------------
module tkb_cell
	import tkb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    new_entry,
	input  entry_t    prev_entry,
	input  logic      prev_valid,
	input  logic      prev_win,
	input  entry_t    next_entry,
	input  logic      next_valid,
	output entry_t    entry,
	output logic      valid,
	output logic      win
);

	entry_t entry_q;
	logic   valid_q;

	assign win   = !valid_q || (new_entry.score > entry_q.score);
	assign entry = entry_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clr) begin
			valid_q <= 1'b0;
		end else if (ctl.ins && win) begin
			valid_q <= prev_win ? prev_valid : 1'b1;
		end else if (ctl.drain) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && win) begin
			entry_q <= prev_win ? prev_entry : new_entry;
		end else if (ctl.drain) begin
			entry_q <= next_entry;
		end
	end

endmodule

// ----- sv/top_k_box_selector.sv -----
// ----------------------------------------------------------------------------
// top_k_box_selector
// Keeps the best boxes of a set in a sorted chain of cells and emits them in
// rank order when the set ends.
// ----------------------------------------------------------------------------
//  channel | signals                        | direction
//  box     | box_valid, box_stall, box      | in, one candidate box
//  rank    | rank_valid, rank_stall, rank   | out, one ranked box
//  cfg     | cfg_valid, cfg_ready, cfg_data | in, max_keep write
//
//  One box is inserted per cycle while box_stall is low; every cell compares against it at once.
//  The box that ends a set starts a drain of min(max_keep, boxes seen) rank
//  transfers (max_keep taken as 1..MAX_KEEP); box_stall stays high during the drain.
//  rank_stall holds the head cell and the chain in place.
//  Reset clears the cell valid bits, the count and sets max_keep to MAX_KEEP.
// ----------------------------------------------------------------------------
module top_k_box_selector
	import tkb_pkg::*;
#(
	parameter int MAX_KEEP = MAX_KEEP_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              box_valid,
	output logic              box_stall,
	input  box_in_t           box,
	output logic              rank_valid,
	input  logic              rank_stall,
	output box_out_t          rank,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [KEEP_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_KEEP + 1);

	logic [KEEP_W-1:0] max_keep_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  remain_q;
	logic              drain_q;

	logic              box_xfer;
	logic              rank_xfer;
	logic [CNT_W-1:0]  count_nxt;
	logic [KEEP_W-1:0] keep;
	logic [KEEP_W-1:0] emit_n;
	cell_ctl_t         ctl;
	entry_t            new_entry;

	entry_t cell_e [MAX_KEEP];
	logic   cell_v [MAX_KEEP];
	logic   cell_w [MAX_KEEP];

	assign cfg_ready  = 1'b1;
	assign box_stall  = drain_q;
	assign box_xfer   = box_valid && !drain_q;
	assign rank_valid = drain_q;
	assign rank_xfer  = drain_q && !rank_stall;

	assign new_entry = '{score: box.score, x0: box.coord_x0, y0: box.coord_y0,
		x1: box.coord_x1, y1: box.coord_y1};

	assign ctl.ins   = box_xfer;
	assign ctl.drain = rank_xfer;
	assign ctl.clr   = rank_xfer && (remain_q == CNT_W'(1));

	assign rank.out_x0    = cell_e[0].x0;
	assign rank.out_y0    = cell_e[0].y0;
	assign rank.out_x1    = cell_e[0].x1;
	assign rank.out_y1    = cell_e[0].y1;
	assign rank.final_box = (remain_q == CNT_W'(1));

	always_comb begin
		count_nxt = (count_q == CNT_W'(MAX_KEEP)) ? count_q : count_q + CNT_W'(1);
		if (max_keep_q > KEEP_W'(MAX_KEEP)) begin
			keep = KEEP_W'(MAX_KEEP);
		end else if (max_keep_q == '0) begin
			keep = KEEP_W'(1);
		end else begin
			keep = max_keep_q;
		end
		emit_n = (KEEP_W'(count_nxt) < keep) ? KEEP_W'(count_nxt) : keep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_keep_q <= KEEP_W'(MAX_KEEP);
			count_q    <= '0;
			remain_q   <= '0;
			drain_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_keep_q <= cfg_data;
			end
			if (box_xfer) begin
				count_q <= count_nxt;
				if (box.set_end) begin
					drain_q  <= 1'b1;
					remain_q <= CNT_W'(emit_n);
				end
			end else if (rank_xfer) begin
				remain_q <= remain_q - CNT_W'(1);
				if (remain_q == CNT_W'(1)) begin
					drain_q <= 1'b0;
					count_q <= '0;
				end
			end
		end
	end

	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		entry_t p_e;
		logic   p_v;
		logic   p_w;
		entry_t n_e;
		logic   n_v;

		if (i == 0) begin : g_head
			assign p_e = new_entry;
			assign p_v = 1'b0;
			assign p_w = 1'b0;
		end else begin : g_body
			assign p_e = cell_e[i-1];
			assign p_v = cell_v[i-1];
			assign p_w = cell_w[i-1];
		end

		if (i == MAX_KEEP - 1) begin : g_tail
			assign n_e = new_entry;
			assign n_v = 1'b0;
		end else begin : g_mid
			assign n_e = cell_e[i+1];
			assign n_v = cell_v[i+1];
		end

		tkb_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.prev_entry (p_e),
			.prev_valid (p_v),
			.prev_win   (p_w),
			.next_entry (n_e),
			.next_valid (n_v),
			.entry      (cell_e[i]),
			.valid      (cell_v[i]),
			.win        (cell_w[i])
		);
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_KEEP))
		else $error("kept count above capacity");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rank_valid |-> cell_v[0])
		else $error("rank transfer offered from an empty head cell");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rank_xfer && rank.final_box) |=> (!rank_valid && count_q == '0))
		else $error("drain did not end after the final box");

	a_drain_len: assert property (@(posedge clk) disable iff (!arst_n)
		rank_valid |-> (remain_q != '0 && remain_q <= count_q))
		else $error("drain length outside kept count");

endmodule
